[src/phit_pkg.sv]
`default_nettype none

package phit_pkg;

    localparam int NUM_REGS       = 32;
    localparam int CYCLE_BITS     = 32;
    localparam int REG_ADDR_BITS  = $clog2(NUM_REGS);
    localparam int REG_FIELD_BITS = 5;
    localparam int OP_BITS        = 2;
    localparam int OPND_COUNT     = 3;
    localparam int MEM_SLOTS      = 3;
    localparam int SLOT_BITS      = $clog2(MEM_SLOTS);
    localparam int STRUCT_LOOK    = MEM_SLOTS + 1;
    localparam int STEP_BITS      = $clog2(STRUCT_LOOK + 1);
    localparam int MEM_STAGE_OFS  = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int FETCH_BITS     = 32;
    localparam int STALL_BITS     = 8;
    localparam int STALL_MAX      = 255;
    localparam int S_TDATA_BITS   = 24;
    localparam int M_TDATA_BITS   = 48;

    localparam logic [OP_BITS-1:0] OP_STORE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_JUMP  = 2'd2;

    typedef logic [CYCLE_BITS-1:0] cycle_t;

    typedef enum logic [1:0] {
        HZ_NONE    = 2'd0,
        HZ_DATA    = 2'd1,
        HZ_STRUCT  = 2'd2,
        HZ_CONTROL = 2'd3
    } hazard_t;

    typedef struct packed {
        logic                     used;
        logic [REG_ADDR_BITS-1:0] addr;
        cycle_t                   ready;
    } opnd_t;

    typedef struct packed {
        logic                     is_jump;
        logic                     dst_en;
        logic [REG_ADDR_BITS-1:0] dst_addr;
        opnd_t [OPND_COUNT-1:0]   opnd;
    } item_t;

    typedef struct packed {
        logic                     en;
        logic [REG_ADDR_BITS-1:0] addr;
        cycle_t                   data;
    } wr_t;

    // forward a ready-time write into an item already past its register read
    function automatic item_t patch_item(input item_t it, input wr_t wr);
        item_t res;
        res = it;
        for (int i = 0; i < OPND_COUNT; i++) begin
            if (wr.en && (it.opnd[i].addr == wr.addr)) begin
                res.opnd[i].ready = wr.data;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/phit_front.sv]
`default_nettype none

module phit_front (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // operation, reg_a, reg_a_valid, reg_b, reg_b_valid, reg_c, reg_c_valid
    input  wire  [phit_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  phit_pkg::wr_t                       wr,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output phit_pkg::item_t                     out_item
);

    logic                     load;
    logic                     fs_valid_reg;
    logic                     fs_valid_next;
    phit_pkg::item_t          dec_item;
    phit_pkg::item_t          fs_item_reg;
    phit_pkg::cycle_t         ready_mem [phit_pkg::OPND_COUNT][phit_pkg::NUM_REGS];
    logic [phit_pkg::NUM_REGS-1:0]    ready_vld_reg;
    phit_pkg::cycle_t         rd_reg     [phit_pkg::OPND_COUNT];
    logic                     ovr_reg    [phit_pkg::OPND_COUNT];
    logic                     ovr_next   [phit_pkg::OPND_COUNT];
    phit_pkg::cycle_t         ovr_val_reg  [phit_pkg::OPND_COUNT];
    phit_pkg::cycle_t         ovr_val_next [phit_pkg::OPND_COUNT];

    function automatic phit_pkg::opnd_t decode_opnd(
        input logic [phit_pkg::REG_FIELD_BITS-1:0] idx,
        input logic                                vld
    );
        phit_pkg::opnd_t o;
        o.used  = vld && (32'(idx) < 32'(phit_pkg::NUM_REGS));
        o.addr  = phit_pkg::REG_ADDR_BITS'(idx);
        o.ready = '0;
        return o;
    endfunction

    assign s_tready  = !fs_valid_reg || out_ready;
    assign load      = s_tvalid && s_tready;
    assign out_valid = fs_valid_reg;

    always_comb begin
        logic [phit_pkg::OP_BITS-1:0] op;
        op               = s_tdata[1:0];
        dec_item.opnd[0] = decode_opnd(s_tdata[6:2], s_tdata[7]);
        dec_item.opnd[1] = decode_opnd(s_tdata[12:8], s_tdata[13]);
        dec_item.opnd[2] = decode_opnd(s_tdata[18:14], s_tdata[19]);
        dec_item.is_jump  = (op == phit_pkg::OP_JUMP);
        dec_item.dst_en   = (op != phit_pkg::OP_STORE) && dec_item.opnd[0].used;
        dec_item.dst_addr = dec_item.opnd[0].addr;
    end

    always_comb begin
        fs_valid_next = fs_valid_reg;
        if (load) begin
            fs_valid_next = 1'b1;
        end else if (out_ready) begin
            fs_valid_next = 1'b0;
        end
    end

    // override path: entry never written since reset, or written after the read
    always_comb begin
        for (int i = 0; i < phit_pkg::OPND_COUNT; i++) begin
            logic hit_new;
            logic hit_old;
            hit_new = wr.en && (wr.addr == dec_item.opnd[i].addr);
            hit_old = wr.en && (wr.addr == fs_item_reg.opnd[i].addr);
            if (load) begin
                ovr_next[i]     = hit_new || !ready_vld_reg[dec_item.opnd[i].addr];
                ovr_val_next[i] = hit_new ? wr.data : '0;
            end else begin
                ovr_next[i]     = ovr_reg[i] || hit_old;
                ovr_val_next[i] = hit_old ? wr.data : ovr_val_reg[i];
            end
        end
    end

    always_comb begin
        out_item = fs_item_reg;
        for (int i = 0; i < phit_pkg::OPND_COUNT; i++) begin
            out_item.opnd[i].ready = ovr_reg[i] ? ovr_val_reg[i] : rd_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_valid_reg  <= 1'b0;
            ready_vld_reg <= '0;
        end else begin
            fs_valid_reg <= fs_valid_next;
            if (wr.en) begin
                ready_vld_reg[wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < phit_pkg::OPND_COUNT; i++) begin
            if (wr.en) begin
                ready_mem[i][wr.addr] <= wr.data;
            end
            if (load) begin
                rd_reg[i] <= ready_mem[i][dec_item.opnd[i].addr];
            end
            ovr_reg[i]     <= ovr_next[i];
            ovr_val_reg[i] <= ovr_val_next[i];
        end
        if (load) begin
            fs_item_reg <= dec_item;
        end
    end

endmodule

`default_nettype wire

[src/phit_queue.sv]
`default_nettype none

module phit_queue (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push_valid,
    output logic              push_ready,
    input  phit_pkg::item_t   push_item,
    output logic              pop_valid,
    input  wire               pop_ready,
    output phit_pkg::item_t   pop_item,
    input  phit_pkg::wr_t     wr
);

    phit_pkg::item_t                 entry_reg [phit_pkg::QUEUE_DEPTH];
    logic [phit_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [phit_pkg::QPTR_BITS-1:0]  wr_ptr_next;
    logic [phit_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [phit_pkg::QPTR_BITS-1:0]  rd_ptr_next;
    logic [phit_pkg::QCNT_BITS-1:0]  count_reg;
    logic [phit_pkg::QCNT_BITS-1:0]  count_next;
    logic                            push;
    logic                            pop;

    function automatic logic [phit_pkg::QPTR_BITS-1:0] ptr_inc(
        input logic [phit_pkg::QPTR_BITS-1:0] p
    );
        return (32'(p) == phit_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (32'(count_reg) != phit_pkg::QUEUE_DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int e = 0; e < phit_pkg::QUEUE_DEPTH; e++) begin
            if (push && (32'(wr_ptr_reg) == e)) begin
                entry_reg[e] <= phit_pkg::patch_item(push_item, wr);
            end else begin
                entry_reg[e] <= phit_pkg::patch_item(entry_reg[e], wr);
            end
        end
    end

endmodule

`default_nettype wire

[src/phit_back.sv]
`default_nettype none

module phit_back (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  phit_pkg::item_t                     in_item,
    output phit_pkg::wr_t                       wr,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // fetch_cycle, stall_cycles, hazard_kind
    output logic [phit_pkg::M_TDATA_BITS-1:0]   m_tdata
);

    phit_pkg::cycle_t                  next_cycle_reg;
    phit_pkg::cycle_t                  slot_reg [phit_pkg::MEM_SLOTS];
    logic [phit_pkg::MEM_SLOTS-1:0]    slot_vld_reg;
    logic [phit_pkg::SLOT_BITS-1:0]    slot_ptr_reg;
    logic [phit_pkg::SLOT_BITS-1:0]    slot_ptr_next;
    logic                              m_tvalid_reg;
    logic                              m_tvalid_next;
    logic [phit_pkg::FETCH_BITS-1:0]   m_fetch_reg;
    logic [phit_pkg::STALL_BITS-1:0]   m_stall_reg;
    phit_pkg::hazard_t                 m_kind_reg;

    logic                              take;
    logic [phit_pkg::STRUCT_LOOK-1:0]  busy;
    logic [phit_pkg::STEP_BITS-1:0]    struct_step;
    phit_pkg::cycle_t                  data_cyc;
    logic                              data_hit;
    phit_pkg::cycle_t                  cyc;
    phit_pkg::cycle_t                  diff;
    phit_pkg::hazard_t                 kind;
    logic [phit_pkg::STALL_BITS-1:0]   stall;

    assign in_ready = !m_tvalid_reg || m_tready;
    assign take     = in_valid && in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(phit_pkg::M_TDATA_BITS - phit_pkg::FETCH_BITS
                        - phit_pkg::STALL_BITS - 2)'(0),
                       m_kind_reg, m_stall_reg, m_fetch_reg};

    // memory-stage occupancy of the next few cycles
    always_comb begin
        for (int j = 0; j < phit_pkg::STRUCT_LOOK; j++) begin
            busy[j] = 1'b0;
            for (int i = 0; i < phit_pkg::MEM_SLOTS; i++) begin
                if (slot_vld_reg[i]
                    && (slot_reg[i] == next_cycle_reg + phit_pkg::cycle_t'(j))) begin
                    busy[j] = 1'b1;
                end
            end
        end
        struct_step = phit_pkg::STEP_BITS'(phit_pkg::STRUCT_LOOK);
        for (int j = phit_pkg::STRUCT_LOOK - 1; j >= 1; j--) begin
            if (!busy[j]) begin
                struct_step = phit_pkg::STEP_BITS'(j);
            end
        end
    end

    // scoreboard check, operands in order a, b, c
    always_comb begin
        data_cyc = next_cycle_reg;
        data_hit = 1'b0;
        for (int i = 0; i < phit_pkg::OPND_COUNT; i++) begin
            if (in_item.opnd[i].used && (in_item.opnd[i].ready > data_cyc)) begin
                data_cyc = in_item.opnd[i].ready + 1'b1;
                data_hit = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (in_item.is_jump) begin
            cyc  = next_cycle_reg;
            kind = phit_pkg::HZ_CONTROL;
        end else if (busy[0]) begin
            cyc  = next_cycle_reg + phit_pkg::cycle_t'(struct_step);
            kind = phit_pkg::HZ_STRUCT;
        end else begin
            cyc  = data_cyc;
            kind = data_hit ? phit_pkg::HZ_DATA : phit_pkg::HZ_NONE;
        end
        diff  = cyc - next_cycle_reg;
        stall = (diff > phit_pkg::cycle_t'(phit_pkg::STALL_MAX))
              ? phit_pkg::STALL_BITS'(phit_pkg::STALL_MAX)
              : diff[phit_pkg::STALL_BITS-1:0];
    end

    always_comb begin
        wr.en   = take && in_item.dst_en;
        wr.addr = in_item.dst_addr;
        wr.data = cyc + phit_pkg::cycle_t'(phit_pkg::MEM_STAGE_OFS);
    end

    always_comb begin
        slot_ptr_next = slot_ptr_reg;
        if (take) begin
            slot_ptr_next = (32'(slot_ptr_reg) == phit_pkg::MEM_SLOTS - 1)
                          ? '0 : slot_ptr_reg + 1'b1;
        end
        m_tvalid_next = m_tvalid_reg;
        if (take) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_cycle_reg <= '0;
            slot_vld_reg   <= '0;
            slot_ptr_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            slot_ptr_reg <= slot_ptr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (take) begin
                next_cycle_reg             <= cyc + 1'b1;
                slot_vld_reg[slot_ptr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            slot_reg[slot_ptr_reg] <= cyc + phit_pkg::cycle_t'(phit_pkg::MEM_STAGE_OFS);
            m_fetch_reg            <= phit_pkg::FETCH_BITS'(cyc);
            m_stall_reg            <= stall;
            m_kind_reg             <= kind;
        end
    end

    a_no_stall_without_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_kind_reg == phit_pkg::HZ_NONE || m_kind_reg == phit_pkg::HZ_CONTROL)
        |-> m_stall_reg == '0)
        else $error("stall reported without a hazard");

    a_struct_stall_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_kind_reg == phit_pkg::HZ_STRUCT
        |-> m_stall_reg >= phit_pkg::STALL_BITS'(1)
            && m_stall_reg <= phit_pkg::STALL_BITS'(phit_pkg::STRUCT_LOOK))
        else $error("structural stall out of range");

    a_no_issue_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |-> !take)
        else $error("issue while result is held");

endmodule

`default_nettype wire

[src/pipeline_hazard_issue_timer.sv]
// Issue timer for a five-stage pipeline with scoreboard hazard detection.
// Input channel s_*: one decoded instruction per transfer (tdata fields from
// bit 0: operation, reg_a, reg_a_valid, reg_b, reg_b_valid, reg_c, reg_c_valid).
// Output channel m_*: one result per instruction, in order (tdata fields from
// bit 0: fetch_cycle, stall_cycles, hazard_kind).
// Path: decode/register-file read stage, two-entry queue, then issue stage
// with output register, which offers the result on m_tvalid. Throughput: one
// instruction per cycle while m_tready is high; the issue stage resolves each
// instruction in a single cycle, as the next one needs its fetch cycle.
// Reset: ready times of all registers read as zero (per-register valid bits),
// memory-stage slots are empty and the cycle counter is zero; no clearing
// pass, so s_tready is up in the first cycle after reset.
// Receiver stall: the output register holds its result; the queue and the
// decode stage keep accepting until both are full (three instructions waiting
// behind the held result, four in flight), then s_tready drops.
`default_nettype none

module pipeline_hazard_issue_timer (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // operation, reg_a, reg_a_valid, reg_b, reg_b_valid, reg_c, reg_c_valid
    input  wire  [phit_pkg::S_TDATA_BITS-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // fetch_cycle, stall_cycles, hazard_kind
    output logic [phit_pkg::M_TDATA_BITS-1:0]   m_tdata
);

    phit_pkg::wr_t    wr;
    logic             fs_valid;
    logic             fs_ready;
    phit_pkg::item_t  fs_item;
    logic             q_valid;
    logic             q_ready;
    phit_pkg::item_t  q_item;

    phit_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .wr        (wr),
        .out_valid (fs_valid),
        .out_ready (fs_ready),
        .out_item  (fs_item)
    );

    phit_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fs_valid),
        .push_ready (fs_ready),
        .push_item  (fs_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item),
        .wr         (wr)
    );

    phit_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .wr       (wr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[tb/tb_pipeline_hazard_issue_timer.sv]
`timescale 1ns / 100ps
`default_nettype none

module tb_pipeline_hazard_issue_timer;

    localparam logic [phit_pkg::OP_BITS-1:0] OP_WRITE   = 2'd0;
    localparam logic [phit_pkg::OP_BITS-1:0] OP_WRITE_B = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        phit_pkg::cycle_t                fetch;
        logic [phit_pkg::STALL_BITS-1:0] stall;
        phit_pkg::hazard_t               kind;
    } issue_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // operation, reg_a, reg_a_valid, reg_b, reg_b_valid, reg_c, reg_c_valid
    logic [phit_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // fetch_cycle, stall_cycles, hazard_kind
    logic [phit_pkg::M_TDATA_BITS-1:0] m_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold = 0;
    int error_count = 0;
    int cycle_count = 0;

    // predicted scoreboard state
    phit_pkg::cycle_t ready_at [phit_pkg::NUM_REGS];
    phit_pkg::cycle_t mem_stage_at [phit_pkg::MEM_SLOTS];
    logic             mem_stage_vld [phit_pkg::MEM_SLOTS];
    int               mem_wr_ptr;
    phit_pkg::cycle_t next_fetch;
    issue_result_t    expected_issue [$];

    pipeline_hazard_issue_timer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, exp);
        error_count++;
    endtask

    // outputs are stable at the falling edge; a transfer seen here completes at the next rise
    always @(negedge aclk) begin : check_results
        issue_result_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_issue.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[31:0], 0);
            end else begin
                exp = expected_issue.pop_front();
                if (m_tdata[31:0] !== exp.fetch)
                    report_mismatch("fetch_cycle", m_tdata[31:0], exp.fetch);
                if (m_tdata[39:32] !== exp.stall)
                    report_mismatch("stall_cycles", m_tdata[39:32], exp.stall);
                if (m_tdata[41:40] !== exp.kind)
                    report_mismatch("hazard_kind", m_tdata[41:40], exp.kind);
            end
        end
    end

    function automatic logic slot_busy(input phit_pkg::cycle_t cyc);
        for (int i = 0; i < phit_pkg::MEM_SLOTS; i++)
            if (mem_stage_vld[i] && mem_stage_at[i] == cyc)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [phit_pkg::S_TDATA_BITS-1:0] pack_instr(
        input logic [phit_pkg::OP_BITS-1:0] op,
        input logic [4:0] ra, input logic rav,
        input logic [4:0] rb, input logic rbv,
        input logic [4:0] rc, input logic rcv);
        return {4'b0, rcv, rc, rbv, rb, rav, ra, op};
    endfunction

    task automatic predict_issue(input logic [phit_pkg::S_TDATA_BITS-1:0] d);
        logic [phit_pkg::OP_BITS-1:0] op;
        logic [4:0] rsel [phit_pkg::OPND_COUNT];
        logic rvld [phit_pkg::OPND_COUNT];
        phit_pkg::cycle_t start, cyc, diff;
        logic hit;
        issue_result_t res;
        op = d[1:0];
        rsel[0] = d[6:2];   rvld[0] = d[7];
        rsel[1] = d[12:8];  rvld[1] = d[13];
        rsel[2] = d[18:14]; rvld[2] = d[19];
        start = next_fetch;
        cyc = start;
        res.kind = phit_pkg::HZ_NONE;
        if (op == phit_pkg::OP_JUMP) begin
            res.kind = phit_pkg::HZ_CONTROL;
        end else if (slot_busy(cyc)) begin
            for (int k = 0; k <= phit_pkg::MEM_SLOTS && slot_busy(cyc); k++)
                cyc = cyc + 1;
            res.kind = phit_pkg::HZ_STRUCT;
        end else begin
            hit = 1'b0;
            for (int i = 0; i < phit_pkg::OPND_COUNT; i++) begin
                if (rvld[i] && ready_at[rsel[i]] > cyc) begin
                    cyc = ready_at[rsel[i]] + 1;
                    hit = 1'b1;
                end
            end
            if (hit)
                res.kind = phit_pkg::HZ_DATA;
        end
        mem_stage_at[mem_wr_ptr] = cyc + phit_pkg::MEM_STAGE_OFS;
        mem_stage_vld[mem_wr_ptr] = 1'b1;
        mem_wr_ptr = (mem_wr_ptr + 1) % phit_pkg::MEM_SLOTS;
        if (op != phit_pkg::OP_STORE && rvld[0])
            ready_at[rsel[0]] = cyc + phit_pkg::MEM_STAGE_OFS;
        next_fetch = cyc + 1;
        diff = cyc - start;
        res.fetch = cyc;
        res.stall = (diff > phit_pkg::STALL_MAX)
                  ? phit_pkg::STALL_BITS'(phit_pkg::STALL_MAX)
                  : diff[phit_pkg::STALL_BITS-1:0];
        expected_issue = {expected_issue, res};
    endtask

    task automatic send_instr(input logic [phit_pkg::S_TDATA_BITS-1:0] d);
        logic took;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        predict_issue(d);
    endtask

    task automatic send_random_instr();
        logic [phit_pkg::OP_BITS-1:0] op;
        logic [4:0] r [phit_pkg::OPND_COUNT];
        logic [2:0] v;
        int p;
        p = $urandom_range(99);
        op = (p < 45) ? OP_WRITE : (p < 65) ? phit_pkg::OP_STORE
           : (p < 80) ? phit_pkg::OP_JUMP : OP_WRITE_B;
        // mostly a small register pool so dependences are frequent
        for (int i = 0; i < phit_pkg::OPND_COUNT; i++)
            r[i] = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
        v = 3'($urandom_range(7));
        send_instr(pack_instr(op, r[0], v[0], r[1], v[1], r[2], v[2]));
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_instr(pack_instr(OP_WRITE,           5'd0,  1'b1, 5'd0,  1'b0, 5'd0,  1'b0));
        send_instr(pack_instr(OP_WRITE,           5'd31, 1'b1, 5'd0,  1'b1, 5'd0,  1'b0));
        send_instr(pack_instr(phit_pkg::OP_JUMP,  5'd0,  1'b0, 5'd31, 1'b1, 5'd0,  1'b0));
        send_instr(pack_instr(phit_pkg::OP_JUMP,  5'd5,  1'b1, 5'd0,  1'b0, 5'd0,  1'b0));
        send_instr(pack_instr(OP_WRITE,           5'd6,  1'b1, 5'd0,  1'b0, 5'd5,  1'b1));
        send_instr(pack_instr(phit_pkg::OP_STORE, 5'd6,  1'b1, 5'd6,  1'b1, 5'd6,  1'b1));
        send_instr(pack_instr(OP_WRITE_B,         5'd7,  1'b1, 5'd6,  1'b1, 5'd0,  1'b0));
        send_instr(pack_instr(OP_WRITE,           5'd7,  1'b1, 5'd0,  1'b0, 5'd0,  1'b0));
        // run of independent ops, then the memory port collides
        send_instr(pack_instr(OP_WRITE,           5'd10, 1'b1, 5'd0,  1'b0, 5'd0,  1'b0));
        send_instr(pack_instr(OP_WRITE,           5'd11, 1'b1, 5'd0,  1'b0, 5'd0,  1'b0));
        send_instr(pack_instr(phit_pkg::OP_STORE, 5'd12, 1'b0, 5'd0,  1'b0, 5'd0,  1'b0));
        send_instr(pack_instr(OP_WRITE,           5'd12, 1'b1, 5'd11, 1'b1, 5'd10, 1'b1));
        send_instr(pack_instr(OP_WRITE,           5'd13, 1'b1, 5'd12, 1'b1, 5'd0,  1'b0));
        send_instr(pack_instr(OP_WRITE_B,         5'd31, 1'b1, 5'd31, 1'b1, 5'd31, 1'b1));
        send_instr(pack_instr(phit_pkg::OP_STORE, 5'd31, 1'b1, 5'd31, 1'b1, 5'd31, 1'b1));
        send_instr(pack_instr(OP_WRITE,           5'd0,  1'b0, 5'd0,  1'b0, 5'd0,  1'b0));
        send_instr(pack_instr(phit_pkg::OP_JUMP,  5'd31, 1'b1, 5'd31, 1'b1, 5'd31, 1'b1));
        send_instr(pack_instr(OP_WRITE,           5'd20, 1'b1, 5'd31, 1'b1, 5'd13, 1'b1));
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_instr();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 300;
        repeat (40) send_random_instr();
    endtask

    initial begin
        for (int i = 0; i < phit_pkg::NUM_REGS; i++)
            ready_at[i] = '0;
        for (int i = 0; i < phit_pkg::MEM_SLOTS; i++) begin
            mem_stage_at[i] = '0;
            mem_stage_vld[i] = 1'b0;
        end
        mem_wr_ptr = 0;
        next_fetch = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(450, 0, 0);
        test_random(450, 51, 0);
        test_random(450, 0, 51);
        test_random(450, 9, 9);
        test_backpressure();

        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_issue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
src/phit_pkg.sv
src/phit_front.sv
src/phit_queue.sv
src/phit_back.sv
src/pipeline_hazard_issue_timer.sv
tb/tb_pipeline_hazard_issue_timer.sv
